FILE: rtl/assert_macros.svh
// Assertion macros for the RTL.
// Each macro takes a label, clock, reset, antecedent, consequent and message.
// Without SYNTHESIS they expand to concurrent assertions; otherwise they vanish.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: rtl/hbsc_pkg.sv
package hbsc_pkg;

   typedef logic [1:0] action_type;

   // Conversion actions
   localparam action_type ACT_HALF_TO_SINGLE = 2'd0;
   localparam action_type ACT_SINGLE_TO_HALF = 2'd1;
   localparam action_type ACT_BF16_TO_SINGLE = 2'd2;
   localparam action_type ACT_SINGLE_TO_BF16 = 2'd3;

   // Half format constants
   localparam logic [4:0]  HALF_EXP_MAX  = 5'h1F;
   localparam logic [14:0] HALF_INF_BITS = 15'h7C00;
   localparam logic [14:0] HALF_NAN_BITS = 15'h7C01;

   // Single format constants
   localparam logic [7:0]  SINGLE_EXP_MAX = 8'hFF;

   // Exponent rebias between formats (127 - 15)
   localparam logic [7:0]  EXP_REBIAS     = 8'd112;
   // Subnormal half exponent base (rebias + 1)
   localparam logic [7:0]  SUB_EXP_BASE   = 8'd113;
   // Single exponents below this flush to signed zero in half
   localparam logic [7:0]  SUB_EXP_FLOOR  = 8'd102;
   // Single exponents at or above this overflow half
   localparam logic [7:0]  OVF_EXP_LIMIT  = 8'd143;

endpackage

FILE: rtl/hbsc_convert.sv
module hbsc_convert
   import hbsc_pkg::*;
(
   input  action_type  action,
   input  logic [31:0] value,
   output logic [31:0] result
);

   // Left shifts that bring the leading one of a nonzero 10-bit mantissa to bit 10
   function automatic logic [3:0] lead_shift(input logic [9:0] m);
      logic [3:0] n;
      n = 4'd11;
      for (int i = 0; i < 10; i++) begin
         if (m[i]) begin
            n = 4'(10 - i);
         end
      end
      return n;
   endfunction

   logic        h_sign;
   logic [4:0]  h_exp;
   logic [9:0]  h_man;
   logic [3:0]  h_shift;
   logic [10:0] h_wide;
   logic [7:0]  h_sub_exp;
   logic [31:0] h2s;

   logic        s_sign;
   logic [7:0]  s_exp;
   logic [22:0] s_full;
   logic [9:0]  s_man;
   logic [3:0]  s_shift;
   logic [10:0] s_sub;
   logic [4:0]  s_half_exp;
   logic [15:0] s2h;

   // Half to single: normalize subnormals with a leading-zero count
   always_comb begin
      h_sign    = value[15];
      h_exp     = value[14:10];
      h_man     = value[9:0];
      h_shift   = lead_shift(h_man);
      h_wide    = {1'b0, h_man} << h_shift;
      h_sub_exp = SUB_EXP_BASE - {4'd0, h_shift};
      if (h_exp == 5'd0) begin
         if (h_man == 10'd0) begin
            h2s = {h_sign, 31'd0};
         end else begin
            h2s = {h_sign, h_sub_exp, h_wide[9:0], 13'd0};
         end
      end else if (h_exp == HALF_EXP_MAX) begin
         h2s = {h_sign, SINGLE_EXP_MAX, h_man, 13'd0};
      end else begin
         h2s = {h_sign, {3'd0, h_exp} + EXP_REBIAS, h_man, 13'd0};
      end
   end

   // Single to half: truncate, shift into subnormals, flush or saturate
   always_comb begin
      s_sign     = value[31];
      s_exp      = value[30:23];
      s_full     = value[22:0];
      s_man      = value[22:13];
      s_shift    = 4'(SUB_EXP_BASE - s_exp);
      s_sub      = {1'b1, s_man} >> s_shift;
      s_half_exp = 5'(s_exp - EXP_REBIAS);
      if (s_exp == SINGLE_EXP_MAX) begin
         if (s_full != 23'd0) begin
            s2h = {s_sign, HALF_NAN_BITS};
         end else begin
            s2h = {s_sign, HALF_INF_BITS};
         end
      end else if (s_exp < SUB_EXP_FLOOR) begin
         s2h = {s_sign, 15'd0};
      end else if (s_exp < SUB_EXP_BASE) begin
         s2h = {s_sign, 5'd0, s_sub[9:0]};
      end else if (s_exp >= OVF_EXP_LIMIT) begin
         s2h = {s_sign, HALF_INF_BITS};
      end else begin
         s2h = {s_sign, s_half_exp, s_man};
      end
   end

   // Select the requested conversion
   always_comb begin
      case (action)
         ACT_HALF_TO_SINGLE: result = h2s;
         ACT_SINGLE_TO_HALF: result = {16'd0, s2h};
         ACT_BF16_TO_SINGLE: result = {value[15:0], 16'd0};
         default:            result = {16'd0, value[31:16]};
      endcase
   end

endmodule

FILE: rtl/half_bfloat_single_converter.sv
// Converter between half, bfloat16 and single precision bit patterns.
// Request channel (req_valid/req_ready): req_action selects half to single,
// single to half, bfloat16 to single or single to bfloat16; req_value holds
// the operand, sixteen-bit sources in bits 15..0.
// Response channel (rsp_valid/rsp_ready): rsp_result holds the converted
// word, sixteen-bit results in bits 15..0 with the upper half zero.
// Every request gives exactly one response, in order.
// A transaction accepted on the request channel is registered at the input,
// converted by the combinational conversion logic and captured in the result
// register that drives rsp_result. Throughput is one transaction per cycle
// while rsp_ready stays high, set by the two-register pipeline.
// When the receiver stalls, the result register holds its transaction and
// the input register still fills; req_ready drops only once both are full.
// Synchronous active-high reset empties both registers; req_ready is high
// right after reset.
module half_bfloat_single_converter
   import hbsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  action_type  req_action,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result
);

`include "assert_macros.svh"

   logic        in_valid_ff;
   action_type  in_action_ff;
   logic [31:0] in_value_ff;
   logic        out_valid_ff;
   logic [31:0] out_result_ff;
   logic [31:0] out_result_in;
   logic        out_ready;
   logic        in_load;
   logic        out_load;

   // Advance a stage when the one after it is empty or draining
   assign out_ready = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || out_ready;
   assign in_load   = req_valid && req_ready;
   assign out_load  = in_valid_ff && out_ready;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_action_ff <= req_action;
         in_value_ff  <= req_value;
      end
   end

   // Conversion logic
   hbsc_convert u_convert (
      .action (in_action_ff),
      .value  (in_value_ff),
      .result (out_result_in)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_result_ff <= out_result_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_result_ff;

   // Checks on the pipeline
   `ASSERT_NEXT(a_accept_fills, clock, reset, in_load, in_valid_ff,
                "accepted transaction not held in input register")
   `ASSERT_NEXT(a_stall_keeps, clock, reset, in_valid_ff && !out_ready, in_valid_ff,
                "input transaction dropped while stalled")
   `ASSERT_NEXT(a_advance, clock, reset, out_load, out_valid_ff,
                "converted transaction not captured")
   `ASSERT_NEXT(a_narrow_upper, clock, reset,
                out_load && (in_action_ff == ACT_SINGLE_TO_HALF ||
                             in_action_ff == ACT_SINGLE_TO_BF16),
                rsp_result[31:16] == 16'd0,
                "sixteen-bit result has nonzero upper half")

endmodule

FILE: tb/half_bfloat_single_converter_tb.sv
`timescale 1ns / 1ps

module half_bfloat_single_converter_tb;
   import hbsc_pkg::*;

   // One pending conversion: what went in and the word that must come out
   typedef struct {
      action_type  action;
      logic [31:0] value;
      logic [31:0] word;
   } conversion_type;

   // Scoreboard: predicts each converted word and checks responses in order
   class conversion_scoreboard;
      conversion_type pending_words[$];
      int             errors;

      function new();
         errors = 0;
      endfunction

      // Half to single, exact; subnormals normalized by a leading-zero walk
      function automatic logic [31:0] expand_half(logic [15:0] h);
         logic [4:0]  hexp;
         logic [10:0] sig;
         logic [7:0]  sexp;
         int          lead;
         hexp = h[14:10];
         sig  = {1'b0, h[9:0]};
         if (hexp == 5'd0) begin
            if (sig == 11'd0) return {h[15], 31'd0};
            lead = 0;
            while (!sig[10]) begin
               sig  = sig << 1;
               lead = lead + 1;
            end
            sexp = SUB_EXP_BASE - 8'(lead);
            return {h[15], sexp, sig[9:0], 13'd0};
         end
         if (hexp == HALF_EXP_MAX) return {h[15], SINGLE_EXP_MAX, h[9:0], 13'd0};
         sexp = 8'(hexp) + EXP_REBIAS;
         return {h[15], sexp, h[9:0], 13'd0};
      endfunction

      // Single to half: truncate, shift into subnormals, flush or saturate
      function automatic logic [15:0] narrow_to_half(logic [31:0] f);
         logic        sign;
         logic [7:0]  sexp;
         logic [22:0] frac;
         logic [10:0] sig;
         int          unb;
         sign = f[31];
         sexp = f[30:23];
         frac = f[22:0];
         unb  = int'(sexp) - 112;
         if (sexp == SINGLE_EXP_MAX)
            return {sign, (frac != 23'd0) ? HALF_NAN_BITS : HALF_INF_BITS};
         if (unb <= 0) begin
            if (unb < -10) return {sign, 15'd0};
            sig = {1'b1, frac[22:13]};
            sig = sig >> (1 - unb);
            return {sign, 4'd0, sig};
         end
         if (unb >= 31) return {sign, HALF_INF_BITS};
         return {sign, 5'(unb), frac[22:13]};
      endfunction

      function automatic logic [31:0] convert_word(action_type action, logic [31:0] value);
         case (action)
            ACT_HALF_TO_SINGLE: return expand_half(value[15:0]);
            ACT_SINGLE_TO_HALF: return {16'd0, narrow_to_half(value)};
            ACT_BF16_TO_SINGLE: return {value[15:0], 16'd0};
            default:            return {16'd0, value[31:16]};
         endcase
      endfunction

      // Print one mismatch line and count it
      task report(string msg);
         $display("%0t ns: mismatch: %s", $time, msg);
         errors = errors + 1;
      endtask

      task note_request(action_type action, logic [31:0] value);
         conversion_type item;
         item.action = action;
         item.value  = value;
         item.word   = convert_word(action, value);
         pending_words.push_back(item);
      endtask

      task check_response(logic [31:0] result);
         conversion_type item;
         if (pending_words.size() == 0) begin
            report($sformatf("unexpected response %08h", result));
         end else begin
            item = pending_words.pop_front();
            if (result !== item.word)
               report($sformatf("action %0d value %08h: result %08h, want %08h",
                                item.action, item.value, result, item.word));
         end
      endtask

      function int pending_count();
         return pending_words.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   action_type  req_action = ACT_HALF_TO_SINGLE;
   logic [31:0] req_value = 32'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_result;

   bit          no_idle = 1'b0;

   conversion_scoreboard board = new();

   half_bfloat_single_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   // Free-running clock, 12 ns period
   always #6 clock = ~clock;

   // Mostly short gaps, a few long ones, none during quiet stretches
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   // Half operand with a chosen exponent class; junk in the upper half
   function automatic logic [31:0] half_operand();
      logic [4:0] hexp;
      logic [9:0] man;
      int         r;
      r = $urandom_range(0, 7);
      if (r == 0)      hexp = 5'd0;
      else if (r == 1) hexp = HALF_EXP_MAX;
      else             hexp = 5'($urandom_range(1, 30));
      man = ($urandom_range(0, 4) == 0) ? 10'd0 : 10'($urandom);
      return {16'($urandom), 1'($urandom), hexp, man};
   endfunction

   // Single operand, exponent weighted around the half range boundaries
   function automatic logic [31:0] single_operand();
      logic [7:0]  sexp;
      logic [22:0] frac;
      int          r;
      r = $urandom_range(0, 9);
      if (r == 0)      sexp = 8'd0;
      else if (r == 1) sexp = SINGLE_EXP_MAX;
      else if (r < 8)  sexp = 8'($urandom_range(98, 146));
      else             sexp = 8'($urandom);
      frac = ($urandom_range(0, 5) == 0) ? 23'd0 : 23'($urandom);
      return {1'($urandom), sexp, frac};
   endfunction

   function automatic logic [31:0] random_operand(action_type action);
      if ($urandom_range(0, 3) == 0) return $urandom;
      case (action)
         ACT_HALF_TO_SINGLE: return half_operand();
         ACT_SINGLE_TO_HALF: return single_operand();
         ACT_BF16_TO_SINGLE: return {16'($urandom), 16'(single_operand() >> 16)};
         default:            return single_operand();
      endcase
   endfunction

   // Present one transaction after an optional gap; return at its accepting edge
   task automatic send_request(action_type action, logic [31:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= action;
      req_value  <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Receiver: stall at random, then stay ready for a while
   initial begin : receiver
      int stall;
      int hold;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         hold = $urandom_range(1, 8);
         repeat (hold) @(posedge clock);
      end
   end

   // Watch both channels; note requests before checking responses
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_request(req_action, req_value);
         if (rsp_valid && rsp_ready) board.check_response(rsp_result);
      end
   end

   initial begin : stimulus
      logic [33:0] directed_list [25];
      int          n;
      action_type  action;

      directed_list = '{
         {ACT_HALF_TO_SINGLE, 32'hFFFF0000}, {ACT_HALF_TO_SINGLE, 32'h00008000},
         {ACT_HALF_TO_SINGLE, 32'h00000001}, {ACT_HALF_TO_SINGLE, 32'h000003FF},
         {ACT_HALF_TO_SINGLE, 32'h00000200}, {ACT_HALF_TO_SINGLE, 32'h00008400},
         {ACT_HALF_TO_SINGLE, 32'h00007BFF}, {ACT_HALF_TO_SINGLE, 32'h00007C00},
         {ACT_HALF_TO_SINGLE, 32'hABCDFC00}, {ACT_HALF_TO_SINGLE, 32'h00007E00},
         {ACT_SINGLE_TO_HALF, 32'h00000000}, {ACT_SINGLE_TO_HALF, 32'h80000000},
         {ACT_SINGLE_TO_HALF, 32'h7F800000}, {ACT_SINGLE_TO_HALF, 32'hFF800001},
         {ACT_SINGLE_TO_HALF, 32'h7FFFFFFF}, {ACT_SINGLE_TO_HALF, 32'h477FE000},
         {ACT_SINGLE_TO_HALF, 32'h47800000}, {ACT_SINGLE_TO_HALF, 32'h7F7FFFFF},
         {ACT_SINGLE_TO_HALF, 32'h38800000}, {ACT_SINGLE_TO_HALF, 32'h33000000},
         {ACT_SINGLE_TO_HALF, 32'hB2FFFFFF}, {ACT_BF16_TO_SINGLE, 32'hFFFF8000},
         {ACT_BF16_TO_SINGLE, 32'h0000FFFF}, {ACT_SINGLE_TO_BF16, 32'hFFFFFFFF},
         {ACT_SINGLE_TO_BF16, 32'h7FC00001}
      };

      // Hold reset high, then release it
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed corners: zeros, subnormals, limits, infinities and NaNs
      foreach (directed_list[i])
         send_request(action_type'(directed_list[i][33:32]), directed_list[i][31:0]);

      // Random operands, with a quiet stretch of back-to-back traffic every 400
      for (n = 0; n < 1750; n++) begin
         no_idle = ((n % 400) >= 300);
         action  = action_type'($urandom_range(0, 3));
         send_request(action, random_operand(action));
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;

      // Drain, then allow the pipeline latency to pass
      while (board.pending_count() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (board.errors == 0 && board.pending_count() == 0) begin
         $display("half_bfloat_single_converter_tb: clean");
      end else begin
         $display("half_bfloat_single_converter_tb: errors");
      end
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #10_000_000;
      $display("half_bfloat_single_converter_tb: errors");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/hbsc_pkg.sv
rtl/hbsc_convert.sv
rtl/half_bfloat_single_converter.sv
tb/half_bfloat_single_converter_tb.sv
